// ===== hdl/dpc_pkg.sv =====
// Shared types, constants and CRC helper functions for the dual-polynomial CRC engine.
package dpc_pkg;

    localparam int C_BYTES_PER_WORD = 8;
    localparam int C_DATA_W         = 64;
    localparam int C_CRC_W          = 32;
    localparam int C_COUNT_IN_W     = 4;
    localparam int C_SEED_W         = 32;
    // Byte lanes actually processed: a 64-bit word never holds more than eight bytes.
    localparam int C_LANES          = (C_BYTES_PER_WORD < (C_DATA_W / 8)) ?
                                      C_BYTES_PER_WORD : (C_DATA_W / 8);
    localparam int C_CNT_W          = $clog2(C_LANES + 1);
    localparam int C_QUEUE_DEPTH    = 2;
    localparam int C_QPTR_W         = (C_QUEUE_DEPTH > 1) ? $clog2(C_QUEUE_DEPTH) : 1;
    localparam int C_QCNT_W         = $clog2(C_QUEUE_DEPTH + 1);

    localparam logic [C_CRC_W:0] C_POLY_CASTAGNOLI_FULL = 33'h105ec76f1;
    localparam logic [C_CRC_W:0] C_POLY_ZLIB_FULL       = 33'h1db710641;

    typedef enum logic {
        POLY_CASTAGNOLI = 1'b0,
        POLY_ZLIB       = 1'b1
    } t_poly_sel;

    // One classified word on its way from the front end to the back end.
    typedef struct packed {
        logic [C_DATA_W-1:0] data_word;
        logic [C_CNT_W-1:0]  byte_count;
        logic                first_word;
        logic [C_SEED_W-1:0] seed_value;
        logic                last_word;
        t_poly_sel           poly_sel;
    } t_work;

    typedef logic [C_CRC_W-1:0][C_CRC_W-1:0]            t_crc_mat;
    typedef logic [1:0][C_LANES:0][C_CRC_W-1:0][C_CRC_W-1:0] t_shift_tbl;

    // Reflected polynomial: drop the x^32 term of the full form.
    function automatic logic [C_CRC_W-1:0] poly_of(t_poly_sel sel);
        return (sel == POLY_ZLIB) ? C_POLY_ZLIB_FULL[C_CRC_W:1]
                                  : C_POLY_CASTAGNOLI_FULL[C_CRC_W:1];
    endfunction

    // Fold one byte into a reflected CRC, one bit per step.
    function automatic logic [C_CRC_W-1:0] absorb_byte(logic [C_CRC_W-1:0] crc,
                                                       logic [7:0] data_byte,
                                                       logic [C_CRC_W-1:0] poly);
        logic [C_CRC_W-1:0] v;
        v = crc ^ {{(C_CRC_W-8){1'b0}}, data_byte};
        for (int b = 0; b < 8; b++) begin
            v = (v >> 1) ^ (poly & {C_CRC_W{v[0]}});
        end
        return v;
    endfunction

    // Column j of each matrix is unit vector j advanced through 8*n zero bits.
    function automatic t_shift_tbl build_shift_tbl();
        t_shift_tbl         tbl;
        logic [C_CRC_W-1:0] v;
        logic [C_CRC_W-1:0] p;
        for (int s = 0; s < 2; s++) begin
            p = poly_of(t_poly_sel'(s));
            for (int n = 0; n <= C_LANES; n++) begin
                for (int j = 0; j < C_CRC_W; j++) begin
                    v = C_CRC_W'(1) << j;
                    for (int b = 0; b < 8 * n; b++) begin
                        v = (v >> 1) ^ (p & {C_CRC_W{v[0]}});
                    end
                    tbl[s][n][j] = v;
                end
            end
        end
        return tbl;
    endfunction

    localparam t_shift_tbl C_SHIFT_TBL = build_shift_tbl();

    // GF(2) matrix times vector: XOR of the columns selected by set bits.
    function automatic logic [C_CRC_W-1:0] mat_apply(t_crc_mat m, logic [C_CRC_W-1:0] x);
        logic [C_CRC_W-1:0] acc;
        acc = '0;
        for (int j = 0; j < C_CRC_W; j++) begin
            acc = acc ^ (m[j] & {C_CRC_W{x[j]}});
        end
        return acc;
    endfunction

endpackage

// ===== hdl/dpc_cfg_if.sv =====
// Configuration write channel carrying the polynomial select bit.
interface dpc_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/dpc_in_if.sv =====
// Input item channel: one data word with its count, seed and framing flags.
interface dpc_in_if;
    import dpc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [C_DATA_W-1:0]     data_word;
    logic [C_COUNT_IN_W-1:0] byte_count;
    logic                    first_word;
    logic [C_SEED_W-1:0]     seed_value;
    logic                    last_word;

    modport source (output valid, output data_word, output byte_count, output first_word,
                    output seed_value, output last_word, input ready);
    modport sink   (input valid, input data_word, input byte_count, input first_word,
                    input seed_value, input last_word, output ready);
endinterface

// ===== hdl/dpc_out_if.sv =====
// Result channel: one CRC value per message.
interface dpc_out_if;
    import dpc_pkg::*;

    logic               valid;
    logic               ready;
    logic [C_CRC_W-1:0] crc_value;

    modport source (output valid, output crc_value, input ready);
    modport sink   (input valid, input crc_value, output ready);
endinterface

// ===== hdl/dual_poly_crc32_update_engine.sv =====
// Top level of the dual-polynomial reflected CRC-32 update engine.
//
// Usage: a message is sent on i_item as 64-bit words, first byte in bits 7:0,
// byte_count giving the valid low bytes (1 to 8; larger counts act as 8, zero
// absorbs nothing). first_word loads seed_value ahead of the word's bytes; a
// message without it continues from the current CRC. On a word with last_word
// set, the updated CRC leaves on o_crc. No inversion is applied on either side.
// i_cfg writes the polynomial select (0 CRC-32C, 1 CRC-32/zlib); write it only
// while the engine is idle. Every item carries the select captured when accepted.
// Throughput: one item per cycle while o_crc is not stalled. A last item goes from the
// queue through the eight byte lanes of the fold pipeline, the first of them taking
// the item out of the queue, and is then combined with the CRC register into the
// result register.
// The CRC register feedback is a single matrix step per word, so it never limits rate.
// When o_crc stalls, the result register holds, the fold pipeline freezes, and the
// two-entry queue keeps accepting items until it fills; then i_item.ready drops.
// Reset clears the CRC to zero, the select to CRC-32C and drops all in-flight items.
module dual_poly_crc32_update_engine (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dpc_cfg_if.sink   i_cfg,
    dpc_in_if.sink    i_item,
    dpc_out_if.source o_crc
);
    import dpc_pkg::*;

    // Front end to queue.
    logic  fq_valid;
    logic  fq_ready;
    t_work fq_item;
    // Queue to back end.
    logic  qb_valid;
    logic  qb_ready;
    t_work qb_item;

    // Classify items and hold the polynomial select.
    dpc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .i_item  (i_item),
        .o_valid (fq_valid),
        .i_ready (fq_ready),
        .o_item  (fq_item)
    );

    // Decouple acceptance from the fold pipeline.
    dpc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fq_valid),
        .o_push_ready (fq_ready),
        .i_push_item  (fq_item),
        .o_pop_valid  (qb_valid),
        .i_pop_ready  (qb_ready),
        .o_pop_item   (qb_item)
    );

    // Fold bytes, advance the CRC register and drive the result.
    dpc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (qb_valid),
        .o_q_ready (qb_ready),
        .i_q_item  (qb_item),
        .o_crc     (o_crc)
    );

endmodule

// ===== hdl/dpc_front.sv =====
// Front end: holds the polynomial select register and classifies incoming items.
module dpc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    dpc_cfg_if.sink        i_cfg,
    dpc_in_if.sink         i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output dpc_pkg::t_work o_item
);
    import dpc_pkg::*;

    t_poly_sel r_poly_sel;
    t_poly_sel n_poly_sel;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_poly_sel = r_poly_sel;
        if (i_cfg.valid) begin
            n_poly_sel = t_poly_sel'(i_cfg.data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly_sel <= POLY_CASTAGNOLI;
        end else begin
            r_poly_sel <= n_poly_sel;
        end
    end

    assign o_valid      = i_item.valid;
    assign i_item.ready = i_ready;

    // Saturate the count to the lanes the back end processes; tag with the polynomial.
    always_comb begin
        o_item.data_word  = i_item.data_word;
        o_item.first_word = i_item.first_word;
        o_item.seed_value = i_item.seed_value;
        o_item.last_word  = i_item.last_word;
        o_item.poly_sel   = r_poly_sel;
        if (i_item.byte_count > C_COUNT_IN_W'(C_LANES)) begin
            o_item.byte_count = C_CNT_W'(C_LANES);
        end else begin
            o_item.byte_count = C_CNT_W'(i_item.byte_count);
        end
    end

endmodule

// ===== hdl/dpc_queue.sv =====
// Short FIFO between the front end and the back end.
module dpc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  dpc_pkg::t_work i_push_item,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output dpc_pkg::t_work o_pop_item
);
    import dpc_pkg::*;

    t_work               r_mem [C_QUEUE_DEPTH];
    logic [C_QPTR_W-1:0] r_wr_ptr;
    logic [C_QPTR_W-1:0] r_rd_ptr;
    logic [C_QCNT_W-1:0] r_count;
    logic [C_QPTR_W-1:0] n_wr_ptr;
    logic [C_QPTR_W-1:0] n_rd_ptr;
    logic [C_QCNT_W-1:0] n_count;
    logic                push;
    logic                pop;

    assign o_push_ready = (r_count != C_QCNT_W'(C_QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == C_QPTR_W'(C_QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == C_QPTR_W'(C_QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= C_QCNT_W'(C_QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && !push |=> r_count == $past(r_count) - 1'b1)
        else $error("queue count did not drop on pop");

endmodule

// ===== hdl/dpc_back.sv =====
// Back end: per-lane byte folding pipeline, CRC register update and result register.
module dpc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    output logic           o_q_ready,
    input  dpc_pkg::t_work i_q_item,
    dpc_out_if.source      o_crc
);
    import dpc_pkg::*;

    logic [C_LANES-1:0] r_vld;
    t_work              r_item [C_LANES];
    logic [C_CRC_W-1:0] r_part [C_LANES];
    logic [C_CRC_W-1:0] r_crc;
    logic               r_out_valid;
    logic [C_CRC_W-1:0] r_out_crc;

    logic [C_LANES-1:0] stg_vld;
    t_work              stg_item [C_LANES];
    logic [C_CRC_W-1:0] stg_part [C_LANES];
    logic [C_CRC_W-1:0] n_part [C_LANES];
    logic [C_CRC_W-1:0] n_crc;
    logic [C_CRC_W-1:0] crc_base;
    logic               en;
    logic               combine;
    t_work              tail;

    // Advance the whole pipeline unless a finished result is still waiting.
    assign en        = !r_out_valid || o_crc.ready;
    assign o_q_ready = en;
    assign tail      = r_item[C_LANES-1];
    assign combine   = en && r_vld[C_LANES-1];

    always_comb begin
        stg_vld[0]  = i_q_valid;
        stg_item[0] = i_q_item;
        stg_part[0] = '0;
        for (int k = 1; k < C_LANES; k++) begin
            stg_vld[k]  = r_vld[k-1];
            stg_item[k] = r_item[k-1];
            stg_part[k] = r_part[k-1];
        end
        // Each lane folds its byte into the data-only partial CRC when in range.
        for (int k = 0; k < C_LANES; k++) begin
            if (stg_item[k].byte_count > C_CNT_W'(k)) begin
                n_part[k] = absorb_byte(stg_part[k], stg_item[k].data_word[8*k +: 8],
                                        poly_of(stg_item[k].poly_sel));
            end else begin
                n_part[k] = stg_part[k];
            end
        end
    end

    // Advance the running CRC (or the seed on a first word) by the word's byte count, then add the data part.
    always_comb begin
        crc_base = tail.first_word ? tail.seed_value : r_crc;
        n_crc    = mat_apply(C_SHIFT_TBL[tail.poly_sel][tail.byte_count], crc_base)
                   ^ r_part[C_LANES-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_crc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (en) begin
                r_vld <= stg_vld;
            end
            if (combine) begin
                r_crc <= n_crc;
            end
            if (combine && tail.last_word) begin
                r_out_valid <= 1'b1;
            end else if (o_crc.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < C_LANES; k++) begin
                r_item[k] <= stg_item[k];
                r_part[k] <= n_part[k];
            end
        end
        if (combine && tail.last_word) begin
            r_out_crc <= n_crc;
        end
    end

    assign o_crc.valid     = r_out_valid;
    assign o_crc.crc_value = r_out_crc;

    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("pipeline moved while stalled");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        combine && tail.last_word |=> r_out_valid)
        else $error("last word produced no result");

    a_crc_only_on_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !combine |=> $stable(r_crc))
        else $error("CRC register changed without a word");

endmodule
